/* hdl/xcpl_pkg.sv */
// package: widths, constants and state codes for the cross-correlation lag estimator
package xcpl_pkg;
	localparam int WINDOW_MAX  = 4096;
	localparam int MAX_LAG     = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_W      = $clog2(WINDOW_MAX);
	localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
	localparam int LAG_W       = $clog2(MAX_LAG + 2) + 1;
	localparam int ACC_W       = 2 * SAMPLE_BITS + CNT_W;
	localparam int CFG_W       = 9;
	localparam int LAGQ_W      = 18;
	localparam int PEAK_W      = 44;
	localparam logic [CFG_W-1:0] MAX_LAG_RESET = CFG_W'(100);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_LAG_INIT,
		ST_MAC,
		ST_MAC_DRAIN,
		ST_LAG_DONE,
		ST_DIV_INIT,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                   start;
		logic signed [LAG_W-1:0] lag;
		logic [CNT_W-1:0]       n;
	} mac_cmd_t;

	typedef struct packed {
		logic                    done;
		logic signed [ACC_W-1:0] sum;
	} mac_rsp_t;
endpackage

/* hdl/xcpl_ram.sv */
// generic single-port-write, single-port-read synchronous ram with registered read
module xcpl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/xcpl_mac.sv */
// sample stores and the multiply-accumulate engine for one correlation lag
module xcpl_mac import xcpl_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ADDR_W-1:0]             wr_addr,
	input  logic signed [SAMPLE_BITS-1:0] wr_robot,
	input  logic signed [SAMPLE_BITS-1:0] wr_oper,
	input  mac_cmd_t                      cmd,
	output mac_rsp_t                      rsp
);
	logic [CNT_W:0] ia_q, ib_q, hi_q;
	logic busy_q, rd_s1, rd_s2, last_s1, last_s2;
	logic [SAMPLE_BITS-1:0] ra, ob;
	logic signed [2*SAMPLE_BITS-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic last_s3, done_q;

	xcpl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_robot (
		.clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_robot),
		.raddr(ia_q[ADDR_W-1:0]), .rdata(ra));
	xcpl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_oper (
		.clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_oper),
		.raddr(ib_q[ADDR_W-1:0]), .rdata(ob));

	logic signed [CNT_W+1:0] n_s, lag_s, lo_b, hi_b;
	always_comb begin
		n_s   = (CNT_W+2)'(cmd.n);
		lag_s = (CNT_W+2)'(cmd.lag);
		lo_b  = (lag_s < 0) ? -lag_s : '0;
		hi_b  = (lag_s < 0) ? n_s : n_s - lag_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; rd_s1 <= 1'b0; rd_s2 <= 1'b0;
			last_s1 <= 1'b0; last_s2 <= 1'b0; last_s3 <= 1'b0; done_q <= 1'b0;
			ia_q <= '0; ib_q <= '0; hi_q <= '0;
		end else begin
			rd_s1 <= 1'b0; last_s1 <= 1'b0;
			if (cmd.start) begin
				// empty range when hi <= lo (|lag| >= n)
				if (hi_b > lo_b) begin
					busy_q <= 1'b1;
					ib_q <= (CNT_W+1)'(lo_b);
					ia_q <= (CNT_W+1)'(lo_b + lag_s);
					hi_q <= (CNT_W+1)'(hi_b);
				end else begin
					busy_q <= 1'b0;
					last_s1 <= 1'b1;
				end
			end else if (busy_q) begin
				rd_s1 <= 1'b1;
				ib_q <= ib_q + 1'b1;
				ia_q <= ia_q + 1'b1;
				if (ib_q + 1'b1 == hi_q) begin
					busy_q <= 1'b0;
					last_s1 <= 1'b1;
				end
			end
			rd_s2 <= rd_s1; last_s2 <= last_s1; last_s3 <= last_s2;
			done_q <= last_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(ra) * $signed(ob);
		if (cmd.start) begin
			acc_q <= '0;
		end else if (rd_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// rd_s1 marks data valid at the ram output in the same cycle; the product lands in prod_s2 as rd_s2 goes high
	assign rsp.done = done_q;
	assign rsp.sum  = acc_q;
endmodule

/* hdl/xcpl_div.sv */
// restoring divider for the rounded parabola offset
module xcpl_div import xcpl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [ACC_W+1:0]    num,
	input  logic [ACC_W+1:0]    den,
	output logic                done,
	output logic [8:0]          quot
);
	logic [ACC_W+1:0] rem_q, den_q;
	logic [8:0] q_q;
	logic [3:0] cnt_q;
	logic busy_q, done_q;
	logic [ACC_W+2:0] trial;
	logic [9:0] rnd;

	// num < 2*den, so 9 steps give floor(256*num/den); rem stays below 2*den
	assign trial = {1'b0, rem_q} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1; cnt_q <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 4'd8) begin
					busy_q <= 1'b0; done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			q_q <= '0;
		end else if (busy_q) begin
			// compare first, then shift the remainder for the next bit
			if (!trial[ACC_W+2]) begin
				rem_q <= {trial[ACC_W:0], 1'b0};
				q_q <= {q_q[7:0], 1'b1};
			end else begin
				rem_q <= {rem_q[ACC_W:0], 1'b0};
				q_q <= {q_q[7:0], 1'b0};
			end
		end
	end

	// halve with round half up: floor((256*num + den) / (2*den))
	assign rnd  = {1'b0, q_q} + 10'd1;
	assign done = done_q;
	assign quot = rnd[9:1];
endmodule

/* hdl/xcorr_peak_lag_estimator.sv */
// top level: window capture, lag sweep sequencer and peak refinement
// each lag walks the two sample memories one read per cycle through one multiplier
// load state takes one item per cycle; results after the last item are held in registers
// reset clears counters, flags and max_lag (to 100); sample memories are not cleared
module xcorr_peak_lag_estimator import xcpl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // robot_sample[15:0], operator_sample[31:16]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // lag_q8[17:0], peak_value[61:18], window_length[74:62]
	output logic [1:0]  m_tuser,  // flat_peak[0], window_overflow[1]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);
	state_t state_q, state_d;
	logic [CFG_W-1:0] max_lag_q;
	logic [CNT_W-1:0] count_q;
	logic ovf_q;
	logic signed [LAG_W-1:0] lag_q, end_q, best_lag_q;
	logic signed [ACC_W-1:0] best_q, nb0_q;
	logic [1:0] phase_q; // 0 sweep, 1 left neighbour, 2 right neighbour
	logic signed [ACC_W+1:0] den_q, num_q;
	mac_cmd_t cmd;
	mac_rsp_t rsp;
	logic div_start, div_done;
	logic [8:0] quot;
	logic accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_LOAD);
	assign accept    = s_tvalid && s_tready;

	xcpl_mac u_mac (
		.clk, .arst_n, .wr_en(accept && count_q < CNT_W'(WINDOW_MAX)),
		.wr_addr(count_q[ADDR_W-1:0]), .wr_robot(s_tdata[15:0]),
		.wr_oper(s_tdata[31:16]), .cmd, .rsp);

	logic [ACC_W+1:0] mag;
	assign mag     = num_q[ACC_W+1] ? -num_q : num_q;
	logic mag_big;
	assign mag_big = {1'b0, mag} >= {den_q, 1'b0};

	xcpl_div u_div (.clk, .arst_n, .start(div_start), .num(mag),
		.den(den_q), .done(div_done), .quot);

	always_comb begin
		state_d = state_q;
		cmd.start = 1'b0;
		cmd.lag = lag_q;
		cmd.n = count_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_LOAD: if (accept && s_tlast) state_d = ST_LAG_INIT;
			ST_LAG_INIT: begin
				cmd.start = 1'b1; state_d = ST_MAC;
			end
			ST_MAC: if (rsp.done) state_d = ST_LAG_DONE;
			ST_MAC_DRAIN: state_d = ST_LAG_DONE;
			ST_LAG_DONE: begin
				if (phase_q == 2'd2) state_d = ST_DIV_INIT;
				else state_d = ST_LAG_INIT;
			end
			ST_DIV_INIT: begin
				if (den_q != 0 && !mag_big) begin
					div_start = 1'b1; state_d = ST_DIV;
				end else state_d = ST_OUT;
			end
			ST_DIV: if (div_done) state_d = ST_OUT;
			ST_OUT: if (m_tvalid && m_tready) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			max_lag_q <= MAX_LAG_RESET;
			count_q <= '0; ovf_q <= 1'b0; phase_q <= '0;
			lag_q <= '0; end_q <= '0; best_lag_q <= '0;
			best_q <= '0; nb0_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) max_lag_q <= cfg_data;
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
				count_q <= '0; ovf_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: if (accept) begin
					if (count_q < CNT_W'(WINDOW_MAX)) count_q <= count_q + 1'b1;
					else ovf_q <= 1'b1;
					if (s_tlast) begin
						phase_q <= 2'd0;
						lag_q <= (max_lag_q > CFG_W'(MAX_LAG)) ?
							-LAG_W'(MAX_LAG) : -LAG_W'(max_lag_q);
						end_q <= (max_lag_q > CFG_W'(MAX_LAG)) ?
							LAG_W'(MAX_LAG) : LAG_W'(max_lag_q);
					end
				end
				ST_LAG_DONE: begin
					unique case (phase_q)
						2'd0: begin
							if (lag_q == -end_q || rsp.sum > best_q) begin
								best_q <= rsp.sum; best_lag_q <= lag_q;
							end
							if (lag_q == end_q) begin
								phase_q <= 2'd1;
								lag_q <= ((lag_q == -end_q || rsp.sum > best_q) ?
									lag_q : best_lag_q) - 1'b1;
							end else lag_q <= lag_q + 1'b1;
						end
						2'd1: begin
							nb0_q <= rsp.sum; phase_q <= 2'd2; lag_q <= best_lag_q + 1'b1;
						end
						default: ;
					endcase
				end
				ST_OUT: if (!m_tvalid) m_tvalid <= 1'b1;
				default: ;
			endcase
		end
	end

	// parabola terms: sign-normalized so den is non-negative; right neighbour straight from the mac
	logic signed [ACC_W+1:0] den_c, num_c;
	assign den_c = (ACC_W+2)'(nb0_q) - ((ACC_W+2)'(best_q) <<< 1) + (ACC_W+2)'(rsp.sum);
	assign num_c = (ACC_W+2)'(nb0_q) - (ACC_W+2)'(rsp.sum);
	always_ff @(posedge clk) begin
		if (state_q == ST_LAG_DONE && phase_q == 2'd2) begin
			den_q <= den_c[ACC_W+1] ? -den_c : den_c;
			num_q <= den_c[ACC_W+1] ? -num_c : num_c;
		end
	end

	logic signed [9:0] off;
	logic flat;
	assign flat = (den_q == 0);
	always_comb begin
		if (flat) off = '0;
		else if (mag_big) off = num_q[ACC_W+1] ? -10'sd256 : 10'sd256;
		else off = num_q[ACC_W+1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
	end

	logic signed [LAGQ_W-1:0] lag_out;
	assign lag_out = (LAGQ_W'(best_lag_q) <<< 8) + LAGQ_W'(off);
	assign m_tdata = {5'd0, count_q, best_q[PEAK_W-1:0], lag_out};
	assign m_tuser = {ovf_q, flat};
endmodule

/* dv/xcorr_peak_lag_estimator_tb.sv */
// testbench: windows of sample pairs against a cross-correlation peak predictor
`timescale 1ns / 100ps

module xcorr_peak_lag_estimator_tb import xcpl_pkg::*; ();

	typedef enum logic [1:0] {IT_PAIR, IT_MAXLAG, IT_DRAIN} entry_kind_t;

	typedef struct {
		entry_kind_t      kind;
		logic [15:0]      robot;
		logic [15:0]      oper;
		logic             last;
		logic [CFG_W-1:0] lag_limit;
	} entry_t;

	typedef struct {
		logic [LAGQ_W-1:0] lag_q8;
		logic [PEAK_W-1:0] peak;
		logic              flat;
		logic              ovf;
		logic [12:0]       len;
	} estimate_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [8:0]  cfg_data = '0;

	xcorr_peak_lag_estimator i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	entry_t    pending[$];
	estimate_t estimates[$];
	int        failures = 0;
	int        windows_seen = 0;
	int        flat_seen = 0;
	int        ovf_seen = 0;
	int        clamp_seen = 0;
	bit        no_gaps = 0;

	// predictor state
	int          rob_mem[WINDOW_MAX];
	int          opr_mem[WINDOW_MAX];
	int          pair_count = 0;
	bit          dropped = 0;
	int unsigned lag_reg = 100;

	function automatic longint corr_sum(int k, int n);
		longint acc;
		int lo, hi;
		acc = 0;
		lo = (k < 0) ? -k : 0;
		hi = (k < 0) ? n : n - k;
		for (int i = lo; i < hi; i++)
			acc += longint'(rob_mem[i + k]) * longint'(opr_mem[i]);
		return acc;
	endfunction

	task automatic absorb_pair(entry_t e);
		estimate_t est;
		int lim, best_k, off;
		longint best, v, left, right, den, num, mag, q;
		if (pair_count < WINDOW_MAX) begin
			rob_mem[pair_count] = int'($signed(e.robot));
			opr_mem[pair_count] = int'($signed(e.oper));
			pair_count++;
		end else begin
			dropped = 1;
		end
		if (!e.last)
			return;
		lim = (lag_reg > MAX_LAG) ? MAX_LAG : lag_reg;
		best_k = -lim;
		best = corr_sum(-lim, pair_count);
		for (int k = -lim + 1; k <= lim; k++) begin
			v = corr_sum(k, pair_count);
			if (v > best) begin
				best = v;
				best_k = k;
			end
		end
		left = corr_sum(best_k - 1, pair_count);
		right = corr_sum(best_k + 1, pair_count);
		den = left - 2 * best + right;
		num = left - right;
		off = 0;
		if (den != 0) begin
			if (den < 0) begin
				den = -den;
				num = -num;
			end
			mag = (num < 0) ? -num : num;
			if (mag >= 2 * den) begin
				q = 256;
				clamp_seen++;
			end else begin
				q = (256 * mag + den) / (2 * den);
			end
			off = (num < 0) ? -int'(q) : int'(q);
		end else begin
			flat_seen++;
		end
		if (dropped)
			ovf_seen++;
		est.lag_q8 = LAGQ_W'(longint'(best_k) * 256 + off);
		est.peak = PEAK_W'(best);
		est.flat = (den == 0);
		est.ovf = dropped;
		est.len = 13'(pair_count);
		estimates.insert(estimates.size(), est);
		pair_count = 0;
		dropped = 0;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// sender
	entry_t cur;
	int     gap_left = 0;
	int     quiet = 0;
	int     sent_items = 0;

	always @(posedge clk) begin
		logic busy_pair, busy_cfg;
		busy_pair = s_tvalid;
		busy_cfg = cfg_valid;
		if (s_tvalid && s_tready) begin
			absorb_pair(cur);
			sent_items++;
			busy_pair = 0;
		end
		if (cfg_valid && cfg_ready) begin
			lag_reg = cur.lag_limit;
			busy_cfg = 0;
		end
		quiet = (estimates.size() == 0 && !busy_pair) ? quiet + 1 : 0;
		if (arst_n && !busy_pair && !busy_cfg) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending.size() > 0) begin
				if (pending[0].kind == IT_PAIR) begin
					cur = pending.pop_front();
					busy_pair = 1;
					gap_left = pick_gap();
				end else if (quiet > 16) begin
					// block is idle: safe to reprogram the lag range
					cur = pending.pop_front();
					busy_cfg = (cur.kind == IT_MAXLAG);
					quiet = 0;
				end
			end
		end
		s_tvalid <= busy_pair;
		cfg_valid <= busy_cfg;
		s_tdata <= {cur.oper, cur.robot};
		s_tlast <= cur.last;
		cfg_data <= cur.lag_limit;
	end

	// receiver
	int stall_left = 0;

	always @(posedge clk) begin
		estimate_t exp_est;
		logic ready_next;
		if (m_tvalid && m_tready) begin
			windows_seen++;
			if (estimates.size() == 0) begin
				$error("unexpected result item: lag_q8=%0d", $signed(m_tdata[17:0]));
				failures++;
			end else begin
				exp_est = estimates.pop_front();
				if (m_tdata[17:0] !== exp_est.lag_q8) begin
					$error("lag_q8 exp %0d got %0d", $signed(exp_est.lag_q8),
						$signed(m_tdata[17:0]));
					failures++;
				end
				if (m_tdata[61:18] !== exp_est.peak) begin
					$error("peak_value exp %0d got %0d", $signed(exp_est.peak),
						$signed(m_tdata[61:18]));
					failures++;
				end
				if (m_tdata[74:62] !== exp_est.len) begin
					$error("window_length exp %0d got %0d", exp_est.len, m_tdata[74:62]);
					failures++;
				end
				if (m_tuser[0] !== exp_est.flat) begin
					$error("flat_peak exp %0d got %0d", exp_est.flat, m_tuser[0]);
					failures++;
				end
				if (m_tuser[1] !== exp_est.ovf) begin
					$error("window_overflow exp %0d got %0d", exp_est.ovf, m_tuser[1]);
					failures++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			ready_next = 0;
		end else begin
			stall_left = pick_gap();
			ready_next = (stall_left == 0);
		end
		m_tready <= ready_next;
	end

	task automatic add_pair(logic [15:0] a, logic [15:0] b, logic last);
		entry_t e;
		e.kind = IT_PAIR;
		e.robot = a;
		e.oper = b;
		e.last = last;
		e.lag_limit = '0;
		pending.insert(pending.size(), e);
	endtask

	task automatic add_lag_limit(int unsigned v);
		entry_t e;
		e.kind = IT_MAXLAG;
		e.robot = '0;
		e.oper = '0;
		e.last = 0;
		e.lag_limit = CFG_W'(v);
		pending.insert(pending.size(), e);
	endtask

	task automatic add_drain();
		entry_t e;
		e.kind = IT_DRAIN;
		e.robot = '0;
		e.oper = '0;
		e.last = 0;
		e.lag_limit = '0;
		pending.insert(pending.size(), e);
	endtask

	// shape 0: noise, 1: operator delayed into robot, 2: small values, 3: rails
	task automatic add_window(int n, int shape, int delay);
		logic [15:0] opr[];
		logic [15:0] a;
		int src;
		opr = new[n];
		foreach (opr[i])
			opr[i] = (shape == 2) ? 16'($signed($urandom_range(0, 14)) - 7) : 16'($urandom);
		for (int i = 0; i < n; i++) begin
			src = i - delay;
			case (shape)
				1: begin
					a = (src >= 0 && src < n) ? opr[src] + 16'($urandom_range(0, 255))
						: 16'($urandom_range(0, 1023));
				end
				3: begin
					a = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
				end
				default: begin
					a = (shape == 2) ? 16'($signed($urandom_range(0, 14)) - 7) : 16'($urandom);
				end
			endcase
			add_pair(a, opr[i], i == n - 1);
		end
	endtask

	initial begin
		int unsigned lim;
		int n, shape;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// directed: reset lag range, rails, silence, zero/one/saturated ranges
		add_pair(16'h7fff, 16'h8000, 0);
		add_pair(16'h8000, 16'h7fff, 1);
		add_pair(16'h8000, 16'h8000, 1);
		add_pair(16'h0000, 16'h0000, 0);
		add_pair(16'h0000, 16'h0000, 0);
		add_pair(16'h0000, 16'h0000, 1);
		add_lag_limit(0);
		add_window(3, 3, 0);
		add_window(1, 0, 0);
		add_lag_limit(1);
		add_window(4, 1, 1);
		add_window(4, 3, 0);
		add_lag_limit(511);
		add_window(4, 0, 0);
		add_lag_limit(256);
		add_window(3, 1, -2);

		while (sent_items + pending.size() < 1150) begin
			if ($urandom_range(0, 99) < 8)
				lim = $urandom_range(256, 511);
			else if ($urandom_range(0, 9) < 3)
				lim = $urandom_range(0, 3);
			else
				lim = $urandom_range(4, 24);
			add_lag_limit(lim);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int w = 0; w < 10; w++) begin
				n = (lim > 24) ? $urandom_range(1, 24) : $urandom_range(1, 20);
				if ($urandom_range(0, 19) == 0)
					n = $urandom_range(40, 90);
				shape = $urandom_range(0, 9);
				shape = (shape < 5) ? 1 : (shape < 7) ? 0 : (shape < 9) ? 2 : 3;
				add_window(n, shape, $signed($urandom_range(0, 2 * n)) - n);
				if ($urandom_range(0, 19) == 0)
					add_drain();
			end
			// hold the feed until the queue of pending items has drained a bit
			while (pending.size() > 200)
				@(posedge clk);
		end

		while (pending.size() > 0 || s_tvalid || cfg_valid || estimates.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d windows from %0d pairs: %0d flat peaks, %0d clamped offsets,",
			windows_seen, sent_items, flat_seen, clamp_seen);
		$display("  %0d overflowed windows, lag ranges from zero to saturated", ovf_seen);
		if (failures == 0 && estimates.size() == 0)
			$display("** xcorr_peak_lag_estimator: PASSED **");
		else
			$display("** xcorr_peak_lag_estimator: FAILED **");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("timeout with %0d results outstanding", estimates.size());
		$display("** xcorr_peak_lag_estimator: FAILED **");
		$finish;
	end
endmodule
